// ----- rtl/core/i2cte_pkg.sv -----
package i2cte_pkg;

	localparam int ADDR_W  = 7;
	localparam int BYTE_W  = 8;
	localparam int PHASE_W = 4;
	localparam int BIDX_W  = 2;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SMC_ADDRESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RTC_ADDRESS = 1'b1;

	localparam logic [ADDR_W-1:0] SMC_ADDRESS_RST = 7'd66;
	localparam logic [ADDR_W-1:0] RTC_ADDRESS_RST = 7'd111;

	// the acknowledge slot follows the last data bit of a byte
	localparam logic [PHASE_W-1:0] PHASE_ACK   = 4'd8;
	localparam logic [PHASE_W-1:0] PHASE_FIRST = 4'd1;
	localparam logic [BIDX_W-1:0]  BIDX_ADDR   = 2'd0;
	localparam logic [BIDX_W-1:0]  BIDX_OFFSET = 2'd1;
	localparam logic [BIDX_W-1:0]  BIDX_DATA   = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] smc_address;
		logic [ADDR_W-1:0] rtc_address;
	} cfg_t;

	typedef struct packed {
		logic              scl_in;
		logic              sda_in;
		logic [BYTE_W-1:0] read_byte;
	} step_in_t;

	typedef struct packed {
		logic              sda_out;
		logic              read_strobe;
		logic              write_strobe;
		logic [ADDR_W-1:0] target_address;
		logic [BYTE_W-1:0] reg_offset;
		logic [BYTE_W-1:0] write_data;
	} step_out_t;

endpackage

// ----- rtl/core/i2cte_in_if.sv -----
interface i2cte_in_if;
	import i2cte_pkg::*;

	logic              valid;
	logic              ready;
	logic              scl_in;
	logic              sda_in;
	logic [BYTE_W-1:0] read_byte;

	modport source (output valid, output scl_in, output sda_in, output read_byte, input ready);
	modport sink   (input valid, input scl_in, input sda_in, input read_byte, output ready);

endinterface

// ----- rtl/core/i2cte_out_if.sv -----
interface i2cte_out_if;
	import i2cte_pkg::*;

	logic              valid;
	logic              ready;
	logic              sda_out;
	logic              read_strobe;
	logic              write_strobe;
	logic [ADDR_W-1:0] target_address;
	logic [BYTE_W-1:0] reg_offset;
	logic [BYTE_W-1:0] write_data;

	modport source (output valid, output sda_out, output read_strobe, output write_strobe,
		output target_address, output reg_offset, output write_data, input ready);
	modport sink   (input valid, input sda_out, input read_strobe, input write_strobe,
		input target_address, input reg_offset, input write_data, output ready);

endinterface

// ----- rtl/core/i2cte_cfg_regs.sv -----
module i2cte_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                we,
	input  logic [i2cte_pkg::CFG_IDX_W-1:0]     index,
	input  logic [i2cte_pkg::ADDR_W-1:0]        data,
	output i2cte_pkg::cfg_t                     cfg
);
	import i2cte_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.smc_address <= SMC_ADDRESS_RST;
			cfg_q.rtc_address <= RTC_ADDRESS_RST;
		end else if (we) begin
			case (index)
				REG_SMC_ADDRESS: cfg_q.smc_address <= data;
				REG_RTC_ADDRESS: cfg_q.rtc_address <= data;
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/i2cte_bit_core.sv -----
module i2cte_bit_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  i2cte_pkg::step_in_t   item,
	input  i2cte_pkg::cfg_t       cfg,
	output i2cte_pkg::step_out_t  res
);
	import i2cte_pkg::*;

	logic               bus_idle_q, reading_q, last_scl_q, last_sda_q, drive_q;
	logic [PHASE_W-1:0] phase_q;
	logic [BYTE_W-1:0]  shift_q, offset_q;
	logic [BIDX_W-1:0]  bidx_q;
	logic [ADDR_W-1:0]  target_q;

	logic               bus_idle_d, reading_d, drive_d;
	logic [PHASE_W-1:0] phase_d;
	logic [BYTE_W-1:0]  shift_d, offset_d, wdata;
	logic [BIDX_W-1:0]  bidx_d;
	logic [ADDR_W-1:0]  target_d;
	logic               changed, rstb, wstb, ack;

	always_comb begin
		bus_idle_d = bus_idle_q;
		reading_d  = reading_q;
		drive_d    = drive_q;
		phase_d    = phase_q;
		shift_d    = shift_q;
		offset_d   = offset_q;
		bidx_d     = bidx_q;
		target_d   = target_q;
		rstb       = 1'b0;
		wstb       = 1'b0;
		wdata      = '0;
		ack        = 1'b1;
		changed    = (item.scl_in != last_scl_q) || (item.sda_in != last_sda_q);

		if (changed) begin
			// start: both lines low while idle
			if (bus_idle_d && !item.scl_in && !item.sda_in) begin
				bus_idle_d = 1'b0;
				phase_d    = '0;
			end
			// stop: sda rises with scl high right after the first bit clock
			if (!bus_idle_d && phase_d == PHASE_FIRST && item.scl_in && item.sda_in
					&& !last_sda_q) begin
				bus_idle_d = 1'b1;
				phase_d    = '0;
				bidx_d     = BIDX_ADDR;
				reading_d  = 1'b0;
			end
			if (!bus_idle_d && item.scl_in && !last_scl_q) begin
				drive_d = 1'b1;
				if (phase_d < PHASE_ACK) begin
					if (reading_d) begin
						if (phase_d == '0) begin
							shift_d = item.read_byte;
							rstb    = 1'b1;
						end
						drive_d = shift_d[BYTE_W-1];
						shift_d = {shift_d[BYTE_W-2:0], 1'b0};
					end else begin
						shift_d = {shift_d[BYTE_W-2:0], item.sda_in};
					end
					phase_d = phase_d + PHASE_W'(1);
				end else begin
					if (reading_d) begin
						// master nack ends the read
						if (item.sda_in) begin
							bidx_d    = BIDX_ADDR;
							reading_d = 1'b0;
						end
					end else begin
						case (bidx_d)
							BIDX_ADDR: begin
								target_d  = shift_d[BYTE_W-1:1];
								reading_d = shift_d[0];
								ack = (target_d == cfg.smc_address)
									|| (target_d == cfg.rtc_address);
							end
							BIDX_OFFSET: offset_d = shift_d;
							default: begin
								wstb     = 1'b1;
								wdata    = shift_d;
								offset_d = offset_q + BYTE_W'(1);
							end
						endcase
						if (ack) begin
							drive_d = 1'b0;
							if (bidx_d != BIDX_DATA) bidx_d = bidx_d + BIDX_W'(1);
						end else begin
							bidx_d    = BIDX_ADDR;
							reading_d = 1'b0;
						end
					end
					phase_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_idle_q <= 1'b1;
			reading_q  <= 1'b0;
			last_scl_q <= 1'b1;
			last_sda_q <= 1'b1;
			drive_q    <= 1'b1;
			phase_q    <= '0;
			shift_q    <= '0;
			offset_q   <= '0;
			bidx_q     <= BIDX_ADDR;
			target_q   <= '0;
		end else if (en) begin
			bus_idle_q <= bus_idle_d;
			reading_q  <= reading_d;
			last_scl_q <= item.scl_in;
			last_sda_q <= item.sda_in;
			drive_q    <= drive_d;
			phase_q    <= phase_d;
			shift_q    <= shift_d;
			offset_q   <= offset_d;
			bidx_q     <= bidx_d;
			target_q   <= target_d;
		end
	end

	always_comb begin
		res.sda_out        = drive_d;
		res.read_strobe    = rstb;
		res.write_strobe   = wstb;
		res.target_address = target_d;
		res.reg_offset     = wstb ? offset_q : offset_d;
		res.write_data     = wdata;
	end

endmodule

// ----- rtl/core/i2c_target_bit_engine.sv -----
// a sample is registered in the input stage, then its result word in the result register
// throughput: one sample word per cycle while the result side is not stalled, set by the bit-state update
// while a result waits one more sample fits in the input stage, then the input stalls
// reset: arst_n clears the bus state to idle with sda released, loads the address
// registers with their defaults and empties both stages
module i2c_target_bit_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	i2cte_in_if.sink                          din,
	i2cte_out_if.source                       dout,
	input  logic                              cfg_we,
	input  logic [i2cte_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [i2cte_pkg::ADDR_W-1:0]      cfg_data
);
	import i2cte_pkg::*;

	cfg_t      cfg;
	step_in_t  item_s1;
	logic      valid_s1;
	step_out_t step_res;
	step_out_t res_q;
	logic      out_valid_q;
	logic      advance;
	logic      in_take;

	// target addresses
	i2cte_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// the staged sample moves on whenever the result register is empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || dout.ready);
	assign din.ready = !valid_s1 || advance;
	assign in_take  = din.valid && din.ready;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.scl_in    <= din.scl_in;
			item_s1.sda_in    <= din.sda_in;
			item_s1.read_byte <= din.read_byte;
		end
	end

	// per-sample state machine: edge detect, start/stop, shift and acknowledge
	i2cte_bit_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (step_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign dout.valid          = out_valid_q;
	assign dout.sda_out        = res_q.sda_out;
	assign dout.read_strobe    = res_q.read_strobe;
	assign dout.write_strobe   = res_q.write_strobe;
	assign dout.target_address = res_q.target_address;
	assign dout.reg_offset     = res_q.reg_offset;
	assign dout.write_data     = res_q.write_data;

endmodule

// ----- tb/sv/i2c_target_bit_checker.sv -----
`timescale 1ns / 100ps

module i2c_target_bit_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	i2cte_in_if                             samples,
	i2cte_out_if                            responses,
	input  logic                            cfg_we,
	input  logic [i2cte_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [i2cte_pkg::ADDR_W-1:0]    cfg_data,
	output int unsigned                     failures,
	output int unsigned                     outstanding
);
	import i2cte_pkg::*;

	logic [ADDR_W-1:0]  smc_addr;
	logic [ADDR_W-1:0]  rtc_addr;

	logic               idle_bus;
	logic [PHASE_W-1:0] phase;
	logic [BYTE_W-1:0]  shifter;
	logic               rd_mode;
	logic [BIDX_W-1:0]  byte_pos;
	logic [ADDR_W-1:0]  target;
	logic [BYTE_W-1:0]  offset;
	logic               prev_scl;
	logic               prev_sda;
	logic               drive;

	step_out_t          bus_responses[$];

	// one pin sample through the bit engine, returns the response word
	function automatic step_out_t advance_bus(step_in_t s);
		step_out_t r;
		logic      acked;
		r = '0;
		if (s.scl_in != prev_scl || s.sda_in != prev_sda) begin
			if (idle_bus && !s.scl_in && !s.sda_in) begin
				idle_bus = 1'b0;
				phase    = '0;
			end
			if (!idle_bus && phase == PHASE_FIRST && s.scl_in && s.sda_in && !prev_sda) begin
				idle_bus = 1'b1;
				phase    = '0;
				byte_pos = BIDX_ADDR;
				rd_mode  = 1'b0;
			end
			if (!idle_bus && s.scl_in && !prev_scl) begin
				drive = 1'b1;
				if (phase < PHASE_ACK) begin
					if (rd_mode) begin
						if (phase == '0) begin
							shifter       = s.read_byte;
							r.read_strobe = 1'b1;
						end
						drive   = shifter[BYTE_W-1];
						shifter = shifter << 1;
					end else begin
						shifter = {shifter[BYTE_W-2:0], s.sda_in};
					end
					phase = phase + PHASE_W'(1);
				end else begin
					if (rd_mode) begin
						// nack from the controller ends the read
						if (s.sda_in) begin
							byte_pos = BIDX_ADDR;
							rd_mode  = 1'b0;
						end
					end else begin
						acked = 1'b1;
						case (byte_pos)
							BIDX_ADDR: begin
								target  = shifter[BYTE_W-1:1];
								rd_mode = shifter[0];
								if (target != smc_addr && target != rtc_addr)
									acked = 1'b0;
							end
							BIDX_OFFSET: begin
								offset = shifter;
							end
							default: begin
								r.write_strobe = 1'b1;
								r.write_data   = shifter;
								r.reg_offset   = offset;
								offset         = offset + BYTE_W'(1);
							end
						endcase
						if (acked) begin
							drive = 1'b0;
							if (byte_pos != BIDX_DATA)
								byte_pos = byte_pos + BIDX_W'(1);
						end else begin
							byte_pos = BIDX_ADDR;
							rd_mode  = 1'b0;
						end
					end
					phase = '0;
				end
			end
			prev_scl = s.scl_in;
			prev_sda = s.sda_in;
		end
		if (!r.write_strobe)
			r.reg_offset = offset;
		r.sda_out        = drive;
		r.target_address = target;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] seen);
		if (want !== seen) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		step_out_t want;
		if (!arst_n) begin
			smc_addr    = SMC_ADDRESS_RST;
			rtc_addr    = RTC_ADDRESS_RST;
			idle_bus    = 1'b1;
			phase       = '0;
			shifter     = '0;
			rd_mode     = 1'b0;
			byte_pos    = BIDX_ADDR;
			target      = '0;
			offset      = '0;
			prev_scl    = 1'b1;
			prev_sda    = 1'b1;
			drive       = 1'b1;
			failures    = 0;
			bus_responses.delete();
			outstanding <= 0;
		end else begin
			if (responses.valid && responses.ready) begin
				if (bus_responses.size() == 0) begin
					$display("%0t: unexpected response word, expected none, actual %0h", $time,
						{responses.sda_out, responses.read_strobe, responses.write_strobe,
						responses.target_address, responses.reg_offset, responses.write_data});
					failures++;
				end else begin
					want = bus_responses.pop_front();
					check_field("sda_out", 8'(want.sda_out), 8'(responses.sda_out));
					check_field("read_strobe", 8'(want.read_strobe),
						8'(responses.read_strobe));
					check_field("write_strobe", 8'(want.write_strobe),
						8'(responses.write_strobe));
					check_field("target_address", 8'(want.target_address),
						8'(responses.target_address));
					check_field("reg_offset", want.reg_offset, responses.reg_offset);
					check_field("write_data", want.write_data, responses.write_data);
				end
			end
			if (samples.valid && samples.ready)
				bus_responses.push_back(advance_bus({samples.scl_in, samples.sda_in,
					samples.read_byte}));
			if (cfg_we) begin
				case (cfg_index)
					REG_SMC_ADDRESS: smc_addr = cfg_data;
					REG_RTC_ADDRESS: rtc_addr = cfg_data;
					default: ;
				endcase
			end
			outstanding <= bus_responses.size();
		end
	end

endmodule

// ----- tb/sv/i2c_target_bit_engine_tb.sv -----
`timescale 1ns / 100ps

module i2c_target_bit_engine_tb;
	import i2cte_pkg::*;

	// generous cycle budget for the slow run
	localparam int unsigned CYCLE_LIMIT = 200000;
	// pin-changing words per configuration phase
	localparam int unsigned PHASE_WORDS = 105;
	localparam int          PHASE_COUNT = 6;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;

	int unsigned          failures;
	int unsigned          outstanding;
	int unsigned          cycle_count;
	int unsigned          words_sent;

	// idle percentages of the two sides, changed per phase
	int unsigned          send_idle_pct;
	int unsigned          recv_idle_pct;

	// stimulus-side view of the pins and of the served addresses
	logic                 pin_scl;
	logic                 pin_sda;
	logic [ADDR_W-1:0]    smc_now;
	logic [ADDR_W-1:0]    rtc_now;

	i2cte_in_if  din_bus ();
	i2cte_out_if dout_bus ();

	i2c_target_bit_engine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din_bus),
		.dout      (dout_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	i2c_target_bit_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (din_bus),
		.responses   (dout_bus),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.failures    (failures),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// response side: random back-pressure
	initial begin
		dout_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			dout_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// one pin sample word, with random idle cycles ahead of it
	task automatic put_sample(input logic scl, input logic sda);
		while ($urandom_range(99) < send_idle_pct) begin
			din_bus.valid <= 1'b0;
			@(posedge clk);
		end
		din_bus.valid     <= 1'b1;
		din_bus.scl_in    <= scl;
		din_bus.sda_in    <= sda;
		din_bus.read_byte <= 8'($urandom_range(255));
		do @(posedge clk); while (!din_bus.ready);
		// words that leave the pins unchanged do nothing, so they are not counted
		if (scl != pin_scl || sda != pin_sda)
			words_sent++;
		pin_scl = scl;
		pin_sda = sda;
	endtask

	// data set up while scl is low, sampled on the rising edge
	task automatic put_bit(input logic b);
		put_sample(1'b0, b);
		// now and then a repeated word with unchanged pins
		if ($urandom_range(15) == 0)
			put_sample(1'b0, b);
		put_sample(1'b1, b);
	endtask

	task automatic put_byte(input logic [BYTE_W-1:0] v);
		for (int i = BYTE_W - 1; i >= 0; i--)
			put_bit(v[i]);
	endtask

	// start: sda falls with scl high, then scl falls
	task automatic begin_xfer();
		put_sample(1'b1, 1'b1);
		put_sample(1'b1, 1'b0);
		put_sample(1'b0, 1'b0);
	endtask

	// stop after an acknowledge slot: one clock with sda low, then sda rises
	task automatic end_xfer();
		put_sample(1'b0, 1'b0);
		put_sample(1'b1, 1'b0);
		put_sample(1'b1, 1'b1);
	endtask

	// repeated stop attempts, enough for one to land on the first bit of a byte; ends idle
	task automatic recover_bus();
		repeat (10) end_xfer();
	endtask

	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] pick_addr();
		case ($urandom_range(4))
			0, 1: return smc_now;
			2, 3: return rtc_now;
			default: return 7'($urandom_range(127));
		endcase
	endfunction

	// one random bus transaction: mostly well formed, some broken or noise
	task automatic random_xfer();
		int unsigned       kind;
		int unsigned       n;
		logic [ADDR_W-1:0] addr;
		kind = $urandom_range(99);
		addr = pick_addr();
		if (kind < 45) begin
			// register write: address, offset, then data bytes
			begin_xfer();
			put_byte({addr, 1'b0});
			put_bit(1'($urandom_range(1)));
			put_byte(pick_byte());
			put_bit(1'($urandom_range(1)));
			n = $urandom_range(4);
			repeat (n) begin
				put_byte(pick_byte());
				put_bit(1'($urandom_range(1)));
			end
			end_xfer();
		end else if (kind < 80) begin
			// register read: ack every byte but the last, which is mostly nacked
			begin_xfer();
			put_byte({addr, 1'b1});
			put_bit(1'($urandom_range(1)));
			n = $urandom_range(1, 3);
			for (int i = 1; i <= n; i++) begin
				put_byte(8'($urandom_range(255)));
				if (i < n)
					put_bit(1'b0);
				else
					put_bit($urandom_range(4) != 0);
			end
			end_xfer();
		end else if (kind < 90) begin
			// transfer cut off at a random bit
			begin_xfer();
			put_byte({addr, 1'($urandom_range(1))});
			n = $urandom_range(20);
			repeat (n) put_bit(1'($urandom_range(1)));
			recover_bus();
		end else begin
			// raw line noise
			n = $urandom_range(5, 30);
			repeat (n) put_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
			recover_bus();
		end
	endtask

	// drain everything, then write both address registers while idle
	task automatic set_addresses(input logic [ADDR_W-1:0] smc, input logic [ADDR_W-1:0] rtc);
		din_bus.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		// let the last response settle before the writes
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SMC_ADDRESS;
		cfg_data  <= smc;
		@(posedge clk);
		cfg_index <= REG_RTC_ADDRESS;
		cfg_data  <= rtc;
		@(posedge clk);
		cfg_we    <= 1'b0;
		smc_now = smc;
		rtc_now = rtc;
	endtask

	initial begin
		int unsigned       mark;
		logic [ADDR_W-1:0] same;
		din_bus.valid     = 1'b0;
		din_bus.scl_in    = 1'b1;
		din_bus.sda_in    = 1'b1;
		din_bus.read_byte = '0;
		cfg_we            = 1'b0;
		cfg_index         = REG_SMC_ADDRESS;
		cfg_data          = '0;
		arst_n            = 1'b0;
		pin_scl           = 1'b1;
		pin_sda           = 1'b1;
		smc_now           = SMC_ADDRESS_RST;
		rtc_now           = RTC_ADDRESS_RST;
		words_sent        = 0;
		send_idle_pct     = 36;
		recv_idle_pct     = 53;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: an idle sample with unchanged pins, then an all-ones address byte,
		// which asks for a read from an address nobody serves, so no ack
		put_sample(1'b1, 1'b1);
		begin_xfer();
		put_byte('1);
		put_bit(1'b1);
		end_xfer();

		for (int p = 0; p < PHASE_COUNT; p++) begin
			// address settings: defaults, both extremes, equal addresses, random
			case (p)
				0: ;
				1: set_addresses('0, '1);
				2: set_addresses('1, '0);
				3: begin
					same = 7'($urandom_range(127));
					set_addresses(same, same);
				end
				default: set_addresses(7'($urandom_range(127)), 7'($urandom_range(127)));
			endcase
			// idling: sender light and receiver heavy, then swapped, then none
			case (p / 2)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 53;
				end
				1: begin
					send_idle_pct = 53;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			mark = words_sent;
			while (words_sent - mark < PHASE_WORDS)
				random_xfer();
		end

		din_bus.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (6) @(posedge clk);

		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- i2c_target_bit_engine.f -----
rtl/core/i2cte_pkg.sv
rtl/core/i2cte_in_if.sv
rtl/core/i2cte_out_if.sv
rtl/core/i2cte_cfg_regs.sv
rtl/core/i2cte_bit_core.sv
rtl/core/i2c_target_bit_engine.sv
tb/sv/i2c_target_bit_checker.sv
tb/sv/i2c_target_bit_engine_tb.sv
